// ===== sv/gbfs_pkg.sv =====
package gbfs_pkg;

	// grid storage
	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 256;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;

	// field widths
	localparam int KIND_W  = 2;
	localparam int TILE_W  = 3;
	localparam int STEP_W  = 4;
	localparam int OUTC_W  = 2;
	localparam int LINES_W = 8;
	localparam int COLS_W  = 9;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// tile classes
	localparam logic [TILE_W-1:0] T_UNKNOWN = 3'd0;
	localparam logic [TILE_W-1:0] T_WALK    = 3'd1;
	localparam logic [TILE_W-1:0] T_ITEM    = 3'd2;
	localparam logic [TILE_W-1:0] T_STAIRS  = 3'd3;

	// first step codes
	localparam logic [STEP_W-1:0] STEP_NONE   = 4'd15;
	localparam logic [STEP_W-1:0] STEP_CENTRE = 4'd4;
	localparam logic [STEP_W-1:0] K_END       = 4'd9;

	// outcomes
	localparam logic [OUTC_W-1:0] OUT_STEP   = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_STAIRS = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_NONE   = 2'd2;

	// configuration register indexes
	localparam logic REG_LINES = 1'b0;
	localparam logic REG_COLS  = 1'b1;

	typedef struct packed {
		logic [LINES_W-1:0] lines;
		logic [COLS_W-1:0]  cols;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [OUTC_W-1:0] outcome;
		logic [STEP_W-1:0] direction;
	} res_t;

	// row (0..2) of a neighbor code
	function automatic logic [1:0] k_row(input logic [STEP_W-1:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	// column (0..2) of a neighbor code
	function automatic logic [1:0] k_col(input logic [STEP_W-1:0] k);
		logic [1:0] c;
		case (k)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default:          c = 2'd2;
		endcase
		return c;
	endfunction

	// a diagonal is refused when exactly one side is walkable
	function automatic logic diag_ok(input logic [8:0] walk, input logic [STEP_W-1:0] k);
		logic ok;
		case (k)
			4'd0:    ok = (walk[1] == walk[3]);
			4'd2:    ok = (walk[1] == walk[5]);
			4'd6:    ok = (walk[7] == walk[3]);
			4'd8:    ok = (walk[7] == walk[5]);
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

// ===== sv/gbfs_item_if.sv =====
interface gbfs_item_if import gbfs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  col;
	logic [TILE_W-1:0] tile;
	logic              stairs_mode;
	logic              start_on_stairs;

	modport source (output valid, kind, row, col, tile, stairs_mode, start_on_stairs,
		input ready);
	modport sink (input valid, kind, row, col, tile, stairs_mode, start_on_stairs,
		output ready);
endinterface

// ===== sv/gbfs_result_if.sv =====
interface gbfs_result_if import gbfs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OUTC_W-1:0] outcome;
	logic [STEP_W-1:0] direction;

	modport source (output valid, outcome, direction, input ready);
	modport sink (input valid, outcome, direction, output ready);
endinterface

// ===== sv/gbfs_cfg_if.sv =====
interface gbfs_cfg_if import gbfs_pkg::*;;
	logic              valid;
	logic              ready;
	logic              index;
	logic [COLS_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/grid_bfs_first_step_unit.sv =====
// Grid search unit: first step towards the nearest target on a tile grid.
// Input channel (in_ch): kind 0 loads one tile cell, kind 2 clears the
// visited map, kind 1 starts a search from row/col in explore or stairs
// mode. One item is taken at a time.
// A search clears the first-step map, one entry a cycle, then walks the
// queue: each dequeued cell passes a queue read, a wait, tile reads of
// its 3x3 block, an evaluate step and first-step reads of its neighbors.
// Standing on stairs in stairs mode skips the search; the stairs outcome
// goes to the done state and from there to the output register.
// Result channel (out_ch): one transfer per search, none for loads, clears
// or searches while the screen exceeds the grid storage.
// The result sits in an output register; loads are still taken while it
// waits; a following search runs, then holds its result and takes no
// input until the receiver takes the waiting one.
// Configuration channel (cfg_ch): index 0 screen lines, 1 screen columns,
// always ready; write only while idle.
// Reset: registers go to 24 lines, 80 columns; the visited map is then
// cleared, and no item is taken until the clear is done.
module grid_bfs_first_step_unit import gbfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gbfs_item_if.sink   in_ch,
	gbfs_result_if.source out_ch,
	gbfs_cfg_if.sink    cfg_ch
);

	cfg_t              cfg_q;
	res_t              res;
	logic              res_take;
	logic              out_valid_q;
	logic [OUTC_W-1:0] outcome_q;
	logic [STEP_W-1:0] direction_q;

	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lines <= LINES_W'(24);
			cfg_q.cols  <= COLS_W'(80);
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_LINES: cfg_q.lines <= cfg_ch.data[LINES_W-1:0];
				REG_COLS:  cfg_q.cols  <= cfg_ch.data;
				default:   cfg_q.cols  <= cfg_q.cols;
			endcase
		end
	end

	gbfs_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_ch(in_ch),
		.res(res), .res_take(res_take)
	);

	// output register
	assign res_take = res.valid && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			outcome_q   <= res.outcome;
			direction_q <= res.direction;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.outcome   = outcome_q;
	assign out_ch.direction = direction_q;

endmodule

// ===== sv/gbfs_ram.sv =====
module gbfs_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/gbfs_engine.sv =====
module gbfs_engine import gbfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	gbfs_item_if.sink   in_ch,
	output res_t        res,
	input  logic        res_take
);

	typedef enum logic [3:0] {
		S_RCLR, S_IDLE, S_VCLR, S_FCLR, S_DEQ, S_DWAIT, S_TRD, S_TEVAL, S_NRD, S_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [STEP_W-1:0] k_q;
	logic [ADDR_W:0]   head_q;
	logic [ADDR_W:0]   tail_q;
	logic [ADDR_W-1:0] cur_q;
	logic [ROW_W-1:0]  sy_q;
	logic [COL_W-1:0]  sx_q;
	logic              stairs_q;
	logic [OUTC_W-1:0] outc_q;
	logic [STEP_W-1:0] dir_q;

	logic [TILE_W-1:0] tile_q [9];
	logic [8:0]        use_q;
	logic [8:0]        st_q;
	logic              vis_cur_q;
	logic [STEP_W-1:0] fs_cur_q;

	logic              rd_v_s1;
	logic [STEP_W-1:0] rd_k_s1;
	logic              rd_use_s1;
	logic              rd_st_s1;
	logic              nv_s1;
	logic [STEP_W-1:0] nk_s1;
	logic [ADDR_W-1:0] na_s1;

	logic [TILE_W-1:0] tile_rdata;
	logic              vis_rdata;
	logic [STEP_W-1:0] fs_rdata;
	logic [ADDR_W-1:0] q_rdata;

	logic              accept;
	logic              too_large;
	logic [ADDR_W-1:0] start_addr;
	logic              stairs_here;

	logic [ROW_W:0]    ny;
	logic [COL_W:0]    nx;
	logic              nb_use;
	logic              nb_st;
	logic [ADDR_W-1:0] nb_addr;

	logic [8:0]        walk;
	logic              unk_any;
	logic              target;
	logic              push;
	logic [STEP_W-1:0] push_step;
	logic              issue_t;
	logic              issue_n;

	logic              t_we;
	logic              v_we, v_wdata, v_re;
	logic [ADDR_W-1:0] v_waddr;
	logic              f_we, f_re;
	logic [ADDR_W-1:0] f_waddr, f_raddr;
	logic [STEP_W-1:0] f_wdata;
	logic              q_we, q_re;
	logic [ADDR_W-1:0] q_waddr, q_wdata;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign too_large   = (cfg.lines > LINES_W'(MAX_ROWS)) || (cfg.cols > COLS_W'(MAX_COLS));
	assign start_addr  = {in_ch.row, in_ch.col};
	assign stairs_here = in_ch.stairs_mode && in_ch.start_on_stairs;

	// neighbor k_q of the current cell
	always_comb begin
		case (k_row(k_q))
			2'd0:    ny = {1'b0, cur_q[ADDR_W-1:COL_W]} - (ROW_W+1)'(1);
			2'd2:    ny = {1'b0, cur_q[ADDR_W-1:COL_W]} + (ROW_W+1)'(1);
			default: ny = {1'b0, cur_q[ADDR_W-1:COL_W]};
		endcase
		case (k_col(k_q))
			2'd0:    nx = {1'b0, cur_q[COL_W-1:0]} - (COL_W+1)'(1);
			2'd2:    nx = {1'b0, cur_q[COL_W-1:0]} + (COL_W+1)'(1);
			default: nx = {1'b0, cur_q[COL_W-1:0]};
		endcase
		nb_use = (ny >= (ROW_W+1)'(1))
			&& (({1'b0, ny} + (ROW_W+2)'(2)) < (ROW_W+2)'(cfg.lines))
			&& (ny < (ROW_W+1)'(MAX_ROWS))
			&& ((COL_W+2)'(nx) < (COL_W+2)'(cfg.cols))
			&& (nx < (COL_W+1)'(MAX_COLS));
		nb_st   = (ny == {1'b0, sy_q}) && (nx == {1'b0, sx_q});
		nb_addr = {ny[ROW_W-1:0], nx[COL_W-1:0]};
	end

	// walkability and target test over the cached 3x3 block
	always_comb begin
		unk_any = 1'b0;
		for (int i = 0; i < 9; i++) begin
			walk[i] = st_q[i] || (use_q[i] && (tile_q[i] == T_WALK
				|| tile_q[i] == T_ITEM || tile_q[i] == T_STAIRS));
			if (use_q[i] && tile_q[i] == T_UNKNOWN) begin
				unk_any = 1'b1;
			end
		end
		if (stairs_q) begin
			target = (tile_q[4] == T_STAIRS);
		end else begin
			target = !vis_cur_q && (tile_q[4] == T_ITEM || unk_any);
		end
	end

	assign issue_t   = (state_q == S_TRD) && (k_q != K_END);
	assign issue_n   = (state_q == S_NRD) && (k_q != K_END) && (k_q != STEP_CENTRE) && nb_use;
	assign push      = nv_s1 && (fs_rdata == STEP_NONE) && walk[nk_s1] && diag_ok(walk, nk_s1);
	assign push_step = st_q[4] ? nk_s1 : fs_cur_q;

	// memory port control
	always_comb begin
		t_we    = accept && (in_ch.kind == KIND_LOAD);
		v_we    = 1'b0;
		v_waddr = cnt_q;
		v_wdata = 1'b0;
		if (state_q == S_RCLR || state_q == S_VCLR) begin
			v_we = 1'b1;
		end else if (accept && in_ch.kind == KIND_SEARCH && !too_large) begin
			v_we    = 1'b1;
			v_waddr = start_addr;
			v_wdata = 1'b1;
		end
		v_re = issue_t && (k_q == '0);

		f_we    = 1'b0;
		f_waddr = cnt_q;
		f_wdata = (cnt_q == {sy_q, sx_q}) ? STEP_CENTRE : STEP_NONE;
		if (state_q == S_FCLR) begin
			f_we = 1'b1;
		end else if (push) begin
			f_we    = 1'b1;
			f_waddr = na_s1;
			f_wdata = push_step;
		end
		f_re    = v_re || issue_n;
		f_raddr = v_re ? cur_q : nb_addr;

		q_we    = 1'b0;
		q_waddr = tail_q[ADDR_W-1:0];
		q_wdata = na_s1;
		if (accept && in_ch.kind == KIND_SEARCH && !too_large && !stairs_here) begin
			q_we    = 1'b1;
			q_waddr = '0;
			q_wdata = start_addr;
		end else if (push) begin
			q_we = 1'b1;
		end
		q_re = (state_q == S_DEQ) && (head_q != tail_q);
	end

	gbfs_ram #(.W(TILE_W), .D(CELLS)) u_tile (
		.clk(clk), .we(t_we), .waddr(start_addr), .wdata(in_ch.tile),
		.re(issue_t), .raddr(nb_addr), .rdata(tile_rdata)
	);

	gbfs_ram #(.W(1), .D(CELLS)) u_visited (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.re(v_re), .raddr(cur_q), .rdata(vis_rdata)
	);

	gbfs_ram #(.W(STEP_W), .D(CELLS)) u_first_step (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.re(f_re), .raddr(f_raddr), .rdata(fs_rdata)
	);

	gbfs_ram #(.W(ADDR_W), .D(CELLS)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.re(q_re), .raddr(head_q[ADDR_W-1:0]), .rdata(q_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RCLR;
			cnt_q    <= '0;
			k_q      <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			rd_v_s1  <= 1'b0;
			nv_s1    <= 1'b0;
			outc_q   <= OUT_NONE;
			dir_q    <= '0;
		end else begin
			rd_v_s1 <= issue_t;
			nv_s1   <= issue_n;
			if (push) begin
				tail_q <= tail_q + (ADDR_W+1)'(1);
			end
			case (state_q)
				S_RCLR, S_VCLR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (accept && in_ch.kind == KIND_CLEAR) begin
						state_q <= S_VCLR;
					end else if (accept && in_ch.kind == KIND_SEARCH && !too_large) begin
						if (stairs_here) begin
							outc_q  <= OUT_STAIRS;
							dir_q   <= '0;
							state_q <= S_DONE;
						end else begin
							head_q  <= '0;
							tail_q  <= (ADDR_W+1)'(1);
							state_q <= S_FCLR;
						end
					end
				end
				S_FCLR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == '1) begin
						state_q <= S_DEQ;
					end
				end
				S_DEQ: begin
					if (head_q == tail_q) begin
						outc_q  <= OUT_NONE;
						dir_q   <= '0;
						state_q <= S_DONE;
					end else begin
						head_q  <= head_q + (ADDR_W+1)'(1);
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					k_q     <= '0;
					state_q <= S_TRD;
				end
				S_TRD: begin
					k_q <= k_q + STEP_W'(1);
					if (k_q == K_END) begin
						state_q <= S_TEVAL;
					end
				end
				S_TEVAL: begin
					k_q <= '0;
					if (!st_q[4] && target) begin
						outc_q  <= OUT_STEP;
						dir_q   <= fs_cur_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NRD;
					end
				end
				S_NRD: begin
					k_q <= k_q + STEP_W'(1);
					if (k_q == K_END) begin
						state_q <= S_DEQ;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (accept && in_ch.kind == KIND_SEARCH) begin
			sy_q     <= in_ch.row;
			sx_q     <= in_ch.col;
			stairs_q <= in_ch.stairs_mode;
		end
		if (state_q == S_DWAIT) begin
			cur_q <= q_rdata;
		end
		rd_k_s1   <= k_q;
		rd_use_s1 <= nb_use;
		rd_st_s1  <= nb_st;
		if (rd_v_s1) begin
			tile_q[rd_k_s1] <= rd_use_s1 ? tile_rdata : T_UNKNOWN;
			use_q[rd_k_s1]  <= rd_use_s1;
			st_q[rd_k_s1]   <= rd_st_s1;
			if (rd_k_s1 == '0) begin
				vis_cur_q <= vis_rdata;
				fs_cur_q  <= fs_rdata;
			end
		end
		nk_s1 <= k_q;
		na_s1 <= nb_addr;
	end

	assign res.valid     = (state_q == S_DONE);
	assign res.outcome   = outc_q;
	assign res.direction = dir_q;

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_step_port: assert property (@(posedge clk) disable iff (!arst_n)
		(f_we && f_re) |-> (f_waddr != f_raddr))
		else $error("first step read and write hit one entry");

	a_push_phase: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ($past(state_q) == S_NRD))
		else $error("queue push outside neighbor pass");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res_take) |=> (res.valid && $stable(res.outcome)))
		else $error("result dropped before transfer");

endmodule
